// ===== rtl/fpa_pkg.sv =====
// Shared types and constants of the fixed-point arithmetic unit.
// No dependencies; every rtl file imports it.
package fpa_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_W      = 6;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int MAX_WIDTH_DEF = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic CFG_INT_BITS  = 1'b0;
  localparam logic CFG_FRAC_BITS = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              divide_by_zero;
  } rsp_t;

  // One pipeline stage: num carries operand, product or numerator;
  // divisor the right magnitude; rem and quo the division state.
  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic              zero_w;
    logic              sa;
    logic              sb;
    logic              neg;
    logic              dz;
    logic [CFG_W-1:0]  f;
    logic [DATA_W-1:0] mask;
    logic [PROD_W-1:0] num;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W:0]   rem;
    logic [DATA_W-1:0] quo;
  } stage_t;

endpackage

// ===== rtl/fpa_div_stage.sv =====
// One registered restoring-division step of the fixed-point unit.
// Depends on fpa_pkg.
module fpa_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  fpa_pkg::stage_t d,
  output fpa_pkg::stage_t q
);
  import fpa_pkg::*;

  stage_t          q_next;
  logic [DATA_W:0] trial;

  always_comb begin
    q_next = d;
    trial  = {d.rem[DATA_W-1:0], d.num[PROD_W-1]};
    if (d.valid && d.op == OP_DIV) begin
      q_next.num = {d.num[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, d.divisor}) begin
        q_next.rem = trial - {1'b0, d.divisor};
        q_next.quo = {d.quo[DATA_W-2:0], 1'b1};
      end else begin
        q_next.rem = trial;
        q_next.quo = {d.quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/fixed_point_alu_unit.sv =====
// Top level of the signed fixed-point arithmetic unit (add, sub, mul, div).
// Depends on fpa_pkg and fpa_div_stage.
//
//   channel | valid     | flow control | payload
//   req     | req_valid | req_stall    | req  (fpa_pkg::req_t)
//   rsp     | rsp_valid | rsp_stall    | rsp  (fpa_pkg::rsp_t)
//   cfg     | cfg_valid | cfg_ready    | cfg_index, cfg_data
//
// One transaction enters per cycle while the response is not stalled; every
// operation takes the same path from the accepting edge to the response
// register (stages B and C, the 64 one-bit restoring division steps, then
// the response register), so the division steps set the latency.
// Reset (synchronous, rst high) empties the pipeline and restores 16.16.
// A stalled response freezes the whole pipeline; nothing is lost or repeated.
module fixed_point_alu_unit #(
  parameter int MAX_WIDTH = fpa_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  fpa_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output fpa_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [fpa_pkg::CFG_W-1:0] cfg_data
);
  import fpa_pkg::*;

  logic [CFG_W-1:0]  int_bits;
  logic [CFG_W-1:0]  frac_bits;
  logic              adv;
  logic [CFG_W:0]    wsum;
  logic [CFG_W-1:0]  w;
  logic [CFG_W-1:0]  f_in;
  logic [DATA_W-1:0] mask_in;
  logic [DATA_W-1:0] a_in;
  logic [DATA_W-1:0] b_in;
  stage_t            sa_next, sa;
  stage_t            sb_next, sb;
  stage_t            sc_next, sc;
  stage_t            dv [DIV_STEPS+1];
  logic [PROD_W-1:0] lost_mask;
  logic [DATA_W-1:0] qv;
  logic              lost;
  rsp_t              rsp_next;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits  <= CFG_W'(16);
      frac_bits <= CFG_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INT_BITS:  int_bits  <= cfg_data;
        CFG_FRAC_BITS: frac_bits <= cfg_data;
        default:       int_bits  <= int_bits;
      endcase
    end
  end

  // Advance whole pipeline unless a finished response is held back.
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // Stage A: format width, fraction width, masked operands and signs.
  always_comb begin
    wsum    = {1'b0, int_bits} + {1'b0, frac_bits};
    w       = (wsum > (CFG_W+1)'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : wsum[CFG_W-1:0];
    f_in    = (frac_bits < w) ? frac_bits : w;
    mask_in = (w == '0) ? '0 : ({DATA_W{1'b1}} >> (CFG_W'(DATA_W) - w));
    a_in    = req.operand_a & mask_in;
    b_in    = req.operand_b & mask_in;
    sa_next         = '0;
    sa_next.valid   = req_valid;
    sa_next.op      = req.req_type;
    sa_next.zero_w  = (w == '0);
    sa_next.f       = f_in;
    sa_next.mask    = mask_in;
    sa_next.num     = {{(PROD_W-DATA_W){1'b0}}, a_in};
    sa_next.divisor = b_in;
    if (w != '0) begin
      sa_next.sa = a_in[5'(w - CFG_W'(1))];
      sa_next.sb = b_in[5'(w - CFG_W'(1))];
    end
  end

  // Stage B: wrap add/sub, magnitudes and sign for mul/div, divide-by-zero flag.
  always_comb begin
    sb_next     = sa;
    sb_next.neg = sa.sa ^ sa.sb;
    if (sa.sa) sb_next.num = {{(PROD_W-DATA_W){1'b0}},
                              (~sa.num[DATA_W-1:0] + DATA_W'(1)) & sa.mask};
    if (sa.sb) sb_next.divisor = (~sa.divisor + DATA_W'(1)) & sa.mask;
    if (sa.op == OP_ADD) sb_next.quo = (sa.num[DATA_W-1:0] + sa.divisor) & sa.mask;
    else if (sa.op == OP_SUB) sb_next.quo = (sa.num[DATA_W-1:0] - sa.divisor) & sa.mask;
    if (sa.zero_w) begin
      sb_next.dz = (sa.op == OP_DIV);
    end else if (sa.op == OP_DIV && sa.divisor == '0) begin
      sb_next.dz  = 1'b1;
      sb_next.neg = 1'b0;
    end
  end

  // Stage C: product, or the shifted numerator for division.
  always_comb begin
    sc_next = sb;
    if (sb.op == OP_MUL) begin
      sc_next.num = PROD_W'(sb.num[DATA_W-1:0]) * PROD_W'(sb.divisor);
    end else if (sb.op == OP_DIV) begin
      sc_next.num = sb.num << sb.f;
      sc_next.rem = '0;
      sc_next.quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
      sb.valid <= 1'b0;
      sc.valid <= 1'b0;
    end else if (adv) begin
      sa <= sa_next;
      sb <= sb_next;
      sc <= sc_next;
    end
  end

  assign dv[0] = sc;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_stage u_step (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  // Final: pick quotient, round toward plus infinity, apply sign and mask.
  always_comb begin
    lost_mask = ~({PROD_W{1'b1}} << dv[DIV_STEPS].f);
    qv        = dv[DIV_STEPS].quo;
    lost      = 1'b0;
    if (dv[DIV_STEPS].op == OP_MUL) begin
      qv   = DATA_W'(dv[DIV_STEPS].num >> dv[DIV_STEPS].f);
      lost = |(dv[DIV_STEPS].num & lost_mask);
    end else if (dv[DIV_STEPS].op == OP_DIV) begin
      lost = |dv[DIV_STEPS].rem;
    end
    if (dv[DIV_STEPS].op == OP_MUL || dv[DIV_STEPS].op == OP_DIV) begin
      if (!dv[DIV_STEPS].neg && lost) qv = qv + DATA_W'(1);
      if (dv[DIV_STEPS].neg) qv = ~qv + DATA_W'(1);
    end
    rsp_next.result_value   = qv & dv[DIV_STEPS].mask;
    rsp_next.divide_by_zero = dv[DIV_STEPS].dz;
    if (dv[DIV_STEPS].dz || dv[DIV_STEPS].zero_w) rsp_next.result_value = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= dv[DIV_STEPS].valid;
      rsp       <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == '0)
    else $error("divide by zero with nonzero result");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && !sa.valid)
    else $error("pipeline not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    req_stall |=> $stable(sc) && $stable(dv[DIV_STEPS]))
    else $error("pipeline moved while stalled");
`endif

endmodule
